// ===== rtl/gc_ct_pkg.sv =====
package gc_ct_pkg;

    // Fixed field widths of the ports
    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 32;
    localparam int SPAN_W     = 20;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CC_W       = 13;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_COUNT = 2'd1;

    // Reset value of the card count register
    localparam logic [CC_W-1:0] CC_RESET = 13'd4096;

    // Command classes passed from front to back
    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_REPLY = 2'd3
    } op_t;

    localparam int OP_W = 2;

    // One result item
    typedef struct packed {
        logic dirty;
        logic out_of_range;
    } res_t;

endpackage

// ===== rtl/gc_ct_ram.sv =====
module gc_ct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gc_ct_fifo.sv =====
module gc_ct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/gc_ct_front.sv =====
module gc_ct_front #(
    parameter int CARD_SHIFT  = 7,
    parameter int TABLE_DEPTH = 4096,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [gc_ct_pkg::MODE_W-1:0]         mode,
    input  logic [gc_ct_pkg::ADDR_W-1:0]         address,
    input  logic [gc_ct_pkg::SPAN_W-1:0]         span_bytes,
    input  logic                                 is_array,
    input  logic                                 cfg_valid,
    input  logic [gc_ct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gc_ct_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 init_busy,
    output logic                                 cq_push,
    output logic [gc_ct_pkg::OP_W+2*$clog2(TABLE_DEPTH):0] cq_data,
    input  logic                                 cq_full
);

    import gc_ct_pkg::*;

    localparam int AW = ADDR_WIDTH;
    localparam int XW = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (AW > LW) ? AW : LW;
    localparam int SW = ((AW > SPAN_W) ? AW : SPAN_W) + 1;

    logic [ADDR_W-1:0] heap_base_reg;
    logic [CC_W-1:0]   card_count_reg;

    logic              s_valid_reg, s_valid_next;
    logic [MODE_W-1:0] s_mode_reg;
    logic [AW-1:0]     s_first_reg;
    logic [AW-1:0]     s_end_reg;
    logic              s_ovf_reg;
    logic              s_array_reg;

    logic [XW-1:0]     addr_x, hb_x;
    logic [AW-1:0]     addr_w, hb_shift, first_w, end_shift, last_w;
    logic [SPAN_W-1:0] span_m1;
    logic [SW-1:0]     end_sum;
    logic              end_ovf;
    logic              accept;

    logic [CW-1:0]     cc_x, depth_c, len_c, first_c, last_c;
    logic              bad_first, bad_query;
    op_t               op;
    logic              oor;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            card_count_reg <= CC_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                CFG_CARD_COUNT: card_count_reg <= cfg_data[CC_W-1:0];
                default:        ;
            endcase
        end
    end

    // Map address to card and compute array end
    always_comb
    begin
        addr_x    = XW'(address);
        addr_w    = addr_x[AW-1:0];
        hb_x      = XW'(heap_base_reg);
        hb_shift  = hb_x[AW-1:0] >> CARD_SHIFT;
        first_w   = (addr_w >> CARD_SHIFT) - hb_shift;
        span_m1   = (span_bytes == '0) ? '0 : span_bytes - 1'b1;
        end_sum   = SW'(addr_w) + SW'(span_m1);
        end_ovf   = |end_sum[SW-1:AW];
        end_shift = end_sum[AW-1:0] >> CARD_SHIFT;
    end

    assign full         = init_busy || (s_valid_reg && cq_full);
    assign accept       = push && !full;
    assign cq_push      = s_valid_reg && !cq_full;
    assign s_valid_next = accept ? 1'b1 : (cq_push ? 1'b0 : s_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_mode_reg  <= mode;
            s_first_reg <= first_w;
            s_end_reg   <= end_shift;
            s_ovf_reg   <= end_ovf;
            s_array_reg <= is_array;
        end
    end

    // Classify the held request against the table length
    always_comb
    begin
        last_w    = s_array_reg ? (s_end_reg - hb_shift) : s_first_reg;
        cc_x      = CW'(card_count_reg);
        depth_c   = CW'(TABLE_DEPTH);
        len_c     = (cc_x > depth_c) ? depth_c : cc_x;
        first_c   = CW'(s_first_reg);
        last_c    = CW'(last_w);
        bad_first = (first_c >= len_c);
        bad_query = (s_array_reg && s_ovf_reg) || bad_first || (last_c >= len_c)
                    || (last_w < s_first_reg);
        unique case (s_mode_reg)
            MODE_MARK:
            begin
                op  = bad_first ? OP_REPLY : OP_MARK;
                oor = bad_first;
            end
            MODE_QUERY:
            begin
                op  = bad_query ? OP_REPLY : OP_QUERY;
                oor = bad_query;
            end
            MODE_CLEAR:
            begin
                op  = OP_CLEAR;
                oor = 1'b0;
            end
            default:
            begin
                op  = OP_REPLY;
                oor = 1'b0;
            end
        endcase
        cq_data = {op, oor, first_c[IW-1:0], last_c[IW-1:0]};
    end

endmodule

// ===== rtl/gc_ct_back.sv =====
module gc_ct_back #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              cq_empty,
    input  logic [gc_ct_pkg::OP_W+2*$clog2(TABLE_DEPTH):0]    cq_data,
    output logic                                              cq_pop,
    input  logic                                              rq_full,
    output logic                                              rq_push,
    output gc_ct_pkg::res_t                                   rq_data,
    output logic                                              init_busy
);

    import gc_ct_pkg::*;

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CMD_W = OP_W + 2 * IW + 1;

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_CLEAR = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] ctr_reg, ctr_next;
    logic [IW-1:0] last_reg, last_next;
    logic          acc_reg, acc_next;
    logic          pend_reg, pend_next;
    res_t          res_reg, res_next;

    op_t           cmd_op;
    logic          cmd_oor;
    logic [IW-1:0] cmd_first, cmd_last;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic          wdata, rdata;

    assign cmd_op    = op_t'(cq_data[CMD_W-1 -: OP_W]);
    assign cmd_oor   = cq_data[2*IW];
    assign cmd_first = cq_data[2*IW-1:IW];
    assign cmd_last  = cq_data[IW-1:0];
    assign init_busy = (state_reg == ST_INIT);

    gc_ct_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Sequence the reset sweep, marks, replies, scans and clearing sweeps
    always_comb
    begin
        state_next = state_reg;
        ctr_next   = ctr_reg;
        last_next  = last_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        pend_next  = (state_reg == ST_SCAN);
        cq_pop     = 1'b0;
        rq_push    = 1'b0;
        rq_data    = res_reg;
        we         = 1'b0;
        waddr      = ctr_reg;
        wdata      = 1'b0;
        raddr      = ctr_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                we = 1'b1;
                if (ctr_reg == IW'(TABLE_DEPTH - 1))
                begin
                    ctr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!cq_empty)
                begin
                    unique case (cmd_op) inside
                        OP_MARK, OP_REPLY:
                        begin
                            if (!rq_full)
                            begin
                                cq_pop               = 1'b1;
                                rq_push              = 1'b1;
                                rq_data.dirty        = 1'b0;
                                rq_data.out_of_range = cmd_oor;
                                if (cmd_op == OP_MARK)
                                begin
                                    we    = 1'b1;
                                    waddr = cmd_first;
                                    wdata = 1'b1;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            cq_pop     = 1'b1;
                            ctr_next   = cmd_first;
                            last_next  = cmd_last;
                            acc_next   = 1'b0;
                            state_next = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            cq_pop     = 1'b1;
                            ctr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                acc_next = acc_reg | (pend_reg & rdata);
                if (ctr_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                res_next.dirty        = acc_reg | rdata;
                res_next.out_of_range = 1'b0;
                state_next            = ST_DONE;
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                if (ctr_reg == IW'(TABLE_DEPTH - 1))
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!rq_full)
                begin
                    rq_push    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ctr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            pend_reg  <= pend_next;
        end
    end

    // Hold scan bound, accumulator and pending result
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

endmodule

// ===== rtl/gc_card_table_engine_core.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------
// input    | in        | push / full        | mode, address, span_bytes, is_array
// result   | out       | pop / empty        | dirty, out_of_range
// config   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A mark or a rejected request is handled in the card table sequencer's idle state;
// a query passes through the scan, drain and done states, the scan reading one card
// per cycle from first card to last; a clear sweeps every entry, then passes done.
// After reset the table is swept clean with full high.
// A two-entry request queue and a two-entry result queue let the front stage
// keep accepting while the sequencer or the result side stalls.
module gc_card_table_engine_core #(
    parameter int CARD_SHIFT  = 7,
    parameter int TABLE_DEPTH = 4096,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [gc_ct_pkg::MODE_W-1:0]     mode,
    input  logic [gc_ct_pkg::ADDR_W-1:0]     address,
    input  logic [gc_ct_pkg::SPAN_W-1:0]     span_bytes,
    input  logic                             is_array,
    output logic                             empty,
    input  logic                             pop,
    output logic                             dirty,
    output logic                             out_of_range,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gc_ct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gc_ct_pkg::CFG_DATA_W-1:0] cfg_data
);

    import gc_ct_pkg::*;

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CMD_W = OP_W + 2 * IW + 1;

    logic             init_busy;
    logic             cq_push, cq_full, cq_pop, cq_empty;
    logic [CMD_W-1:0] cq_din, cq_dout;
    logic             rq_push, rq_full;
    res_t             rq_din, rq_dout;

    assign cfg_ready    = 1'b1;
    assign dirty        = rq_dout.dirty;
    assign out_of_range = rq_dout.out_of_range;

    gc_ct_front #(
        .CARD_SHIFT  (CARD_SHIFT),
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .address    (address),
        .span_bytes (span_bytes),
        .is_array   (is_array),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .init_busy  (init_busy),
        .cq_push    (cq_push),
        .cq_data    (cq_din),
        .cq_full    (cq_full)
    );

    gc_ct_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .din   (cq_din),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (cq_dout),
        .empty (cq_empty)
    );

    gc_ct_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_empty  (cq_empty),
        .cq_data   (cq_dout),
        .cq_pop    (cq_pop),
        .rq_full   (rq_full),
        .rq_push   (rq_push),
        .rq_data   (rq_din),
        .init_busy (init_busy)
    );

    gc_ct_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_din),
        .full  (rq_full),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty)
    );

endmodule

// ===== rtl/gc_ct_checker.sv =====
module gc_ct_checker (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic pop,
    input logic empty,
    input logic dirty,
    input logic out_of_range
);

    // Front stage, two request slots, sequencer and two result slots
    localparam logic [3:0] MAX_INFLIGHT = 4'd6;

    logic [3:0] inflight_reg, inflight_next;
    logic       in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // Track requests accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // No result shows without an outstanding request
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (inflight_reg != 4'd0))
        else $error("result shown with no request outstanding");

    // Storage bounds the number of requests in flight
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= MAX_INFLIGHT)
        else $error("more requests in flight than the block can hold");

    // An out-of-range answer never reports a dirty card
    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(dirty && out_of_range))
        else $error("dirty and out_of_range both set");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(dirty) && $stable(out_of_range)))
        else $error("waiting result changed or vanished");

endmodule

bind gc_card_table_engine_core gc_ct_checker u_chk (.*);

// ===== tb/gc_card_table_checker.sv =====
`timescale 1ns / 1ps

module gc_card_table_checker #(
    parameter int CARD_SHIFT  = 7,
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic [gc_ct_pkg::MODE_W-1:0]     mode,
    input  logic [gc_ct_pkg::ADDR_W-1:0]     address,
    input  logic [gc_ct_pkg::SPAN_W-1:0]     span_bytes,
    input  logic                             is_array,
    input  logic                             empty,
    input  logic                             pop,
    input  logic                             dirty,
    input  logic                             out_of_range,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [gc_ct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gc_ct_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                             moved,
    output int                               fail_count,
    output int                               pending,
    output int                               replies_seen,
    output int                               dirty_seen,
    output int                               oor_seen
);

    import gc_ct_pkg::*;

    // Mirror of the block's registers and card bits
    logic [ADDR_W-1:0] base_reg;
    logic [CC_W-1:0]   count_reg;
    logic              card_mirror [0:TABLE_DEPTH-1];

    res_t expected_replies [$];
    res_t want;
    int   mismatches;
    int   n_replies;
    int   n_dirty;
    int   n_oor;
    int   k;

    // Any request moving on any channel this cycle
    assign moved = (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready);

    function automatic logic [ADDR_W-1:0] card_of(input logic [ADDR_W-1:0] addr);
        return (addr >> CARD_SHIFT) - (base_reg >> CARD_SHIFT);
    endfunction

    // Apply one request to the mirror and return the reply it must produce
    function automatic res_t predict_reply(input logic [MODE_W-1:0] op,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [SPAN_W-1:0] span,
                                           input logic              arr);
        res_t            r;
        logic [ADDR_W-1:0] tbl_len;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] c;
        logic [ADDR_W:0]   end_addr;
        r = '0;
        tbl_len = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
        case (op)
            MODE_MARK: begin
                first = card_of(addr);
                if (first < tbl_len)
                    card_mirror[first] = 1'b1;
                else
                    r.out_of_range = 1'b1;
            end
            MODE_QUERY: begin
                first = card_of(addr);
                last  = first;
                if (arr) begin
                    // zero span counts as a single byte
                    end_addr = {1'b0, addr} - 33'd1 +
                               ((span == '0) ? 33'd1 : {13'd0, span});
                    if (end_addr[ADDR_W])
                        r.out_of_range = 1'b1;
                    else
                        last = card_of(end_addr[ADDR_W-1:0]);
                end
                if (!r.out_of_range &&
                    (first >= tbl_len || last >= tbl_len || last < first))
                    r.out_of_range = 1'b1;
                if (!r.out_of_range)
                    for (c = first; c <= last; c++)
                        if (card_mirror[c])
                            r.dirty = 1'b1;
            end
            MODE_CLEAR: begin
                for (c = 0; c < TABLE_DEPTH; c++)
                    card_mirror[c] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            base_reg  = '0;
            count_reg = CC_RESET;
            for (k = 0; k < TABLE_DEPTH; k++)
                card_mirror[k] = 1'b0;
            expected_replies.delete();
            mismatches = 0;
            n_replies  = 0;
            n_dirty    = 0;
            n_oor      = 0;
        end
        else
        begin
            // Compare the reply leaving the block with the oldest prediction
            if (pop && !empty)
            begin
                n_replies++;
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: reply with no request waiting, got dirty %0b oor %0b",
                             $time, dirty, out_of_range);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (want.dirty)
                        n_dirty++;
                    if (want.out_of_range)
                        n_oor++;
                    if (dirty !== want.dirty)
                    begin
                        mismatches++;
                        $display("%0t: dirty mismatch, expected %0b, got %0b",
                                 $time, want.dirty, dirty);
                    end
                    if (out_of_range !== want.out_of_range)
                    begin
                        mismatches++;
                        $display("%0t: out_of_range mismatch, expected %0b, got %0b",
                                 $time, want.out_of_range, out_of_range);
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE:  base_reg  = cfg_data;
                    CFG_CARD_COUNT: count_reg = cfg_data[CC_W-1:0];
                    default: ;
                endcase
            end

            // Predict the reply of each accepted request
            if (push && !full)
                expected_replies.push_back(predict_reply(mode, address, span_bytes,
                                                         is_array));
        end
        fail_count   <= mismatches;
        pending      <= expected_replies.size();
        replies_seen <= n_replies;
        dirty_seen   <= n_dirty;
        oor_seen     <= n_oor;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import gc_ct_pkg::*;

    localparam int CARD_SHIFT  = 7;
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_WIDTH  = 32;
    localparam int CARD_BYTES  = 1 << CARD_SHIFT;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    // Mode value the block must treat as a no-op
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  push         = 1'b0;
    logic                  full;
    logic [MODE_W-1:0]     mode         = '0;
    logic [ADDR_W-1:0]     address      = '0;
    logic [SPAN_W-1:0]     span_bytes   = '0;
    logic                  is_array     = 1'b0;
    logic                  empty;
    logic                  pop          = 1'b0;
    logic                  dirty;
    logic                  out_of_range;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    logic moved;
    int   fail_count;
    int   pending;
    int   replies_seen;
    int   dirty_seen;
    int   oor_seen;

    // Stimulus shaping and receiver control
    logic [ADDR_W-1:0] cur_base;
    int                cur_len;
    int                tx_gap_pct;
    logic              quiet          = 1'b0;
    int                rx_hold_req    = 0;
    int                rx_hold_served = 0;
    int                rx_gap         = 0;
    int                stalled_cycles = 0;
    int                n_marks        = 0;
    int                n_queries      = 0;
    int                n_clears       = 0;
    int                n_spare        = 0;
    int                n_settings     = 0;

    always #5 clk = ~clk;

    gc_card_table_engine_core #(
        .CARD_SHIFT  (CARD_SHIFT),
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .address      (address),
        .span_bytes   (span_bytes),
        .is_array     (is_array),
        .empty        (empty),
        .pop          (pop),
        .dirty        (dirty),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gc_card_table_checker #(
        .CARD_SHIFT  (CARD_SHIFT),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_card_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .address      (address),
        .span_bytes   (span_bytes),
        .is_array     (is_array),
        .empty        (empty),
        .pop          (pop),
        .dirty        (dirty),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .moved        (moved),
        .fail_count   (fail_count),
        .pending      (pending),
        .replies_seen (replies_seen),
        .dirty_seen   (dirty_seen),
        .oor_seen     (oor_seen)
    );

    // Drain replies; stall in random bursts or hold off for a long stretch on request
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (rx_hold_req != rx_hold_served)
            begin
                rx_hold_served = rx_hold_req;
                rx_gap = HOLD_CYCLES;
            end
            else if (rx_gap == 0 && !quiet && $urandom_range(0, 99) < 8)
                rx_gap = $urandom_range(1, 13);
            if (rx_gap != 0)
            begin
                pop <= 1'b0;
                rx_gap--;
            end
            else
                pop <= 1'b1;
        end
    end

    // End the run when no request moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || moved)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("tb: no request moved for %0d cycles at %0t", STALL_LIMIT, $time);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Set both registers and remember them for address shaping
    task automatic set_table(input logic [ADDR_W-1:0] base, input logic [CC_W-1:0] count);
        write_reg(CFG_HEAP_BASE, base);
        write_reg(CFG_CARD_COUNT, {19'd0, count});
        cur_base = base;
        cur_len  = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        n_settings++;
    endtask

    task automatic send_request(input logic [MODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [SPAN_W-1:0] span, input logic arr);
        push       <= 1'b1;
        mode       <= op;
        address    <= addr;
        span_bytes <= span;
        is_array   <= arr;
        @(posedge clk);
        while (full)
            @(posedge clk);
        case (op)
            MODE_MARK:  n_marks++;
            MODE_QUERY: n_queries++;
            MODE_CLEAR: n_clears++;
            default:    n_spare++;
        endcase
    endtask

    task automatic idle_gap(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop offering requests until every predicted reply has come back
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly cards near the start of the table so marks and queries meet
    task automatic send_random_request();
        int                pick;
        int                win;
        logic [MODE_W-1:0] op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] card0;
        logic [SPAN_W-1:0] span;
        pick = $urandom_range(0, 99);
        if (pick < 52)
            op = MODE_MARK;
        else if (pick < 96)
            op = MODE_QUERY;
        else if (pick < 98)
            op = MODE_CLEAR;
        else
            op = MODE_SPARE;

        card0 = (cur_base >> CARD_SHIFT) << CARD_SHIFT;
        win   = (cur_len < 40) ? cur_len : 40;
        pick  = $urandom_range(0, 99);
        if (pick < 70)
            addr = card0 + $urandom_range(0, win) * CARD_BYTES
                   + $urandom_range(0, CARD_BYTES - 1);
        else if (pick < 80)
            addr = card0 + (cur_len + $urandom_range(0, 3) - 2) * CARD_BYTES
                   + $urandom_range(0, CARD_BYTES - 1);
        else if (pick < 88)
            addr = cur_base - $urandom_range(1, 16384);
        else
            addr = $urandom;

        pick = $urandom_range(0, 99);
        if (pick < 55)
            span = SPAN_W'($urandom_range(0, 4 * CARD_BYTES));
        else if (pick < 80)
            span = SPAN_W'($urandom_range(0, 64 * CARD_BYTES));
        else if (pick < 86)
            span = '0;
        else if (pick < 90)
            span = '1;
        else
            span = SPAN_W'($urandom_range(0, 20'hFFFFF));

        send_request(op, addr, span, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int          ph;
        int          i;
        int          n_items;
        bit          tail;
        logic [ADDR_W-1:0] b;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests on a full-size table
        set_table(32'h0001_0000, 13'd4096);
        b = cur_base;
        send_request(MODE_QUERY, b, 20'd0, 1'b0);
        send_request(MODE_MARK,  b, 20'hFFFFF, 1'b1);
        send_request(MODE_QUERY, b + 5, 20'd0, 1'b0);
        send_request(MODE_MARK,  b + 4095 * CARD_BYTES + 127, 20'd0, 1'b0);
        send_request(MODE_MARK,  b + 4096 * CARD_BYTES, 20'd0, 1'b0);
        send_request(MODE_MARK,  b - 1, 20'd0, 1'b0);
        send_request(MODE_QUERY, b + CARD_BYTES, 20'd0, 1'b1);
        send_request(MODE_QUERY, b + CARD_BYTES, SPAN_W'(4094 * CARD_BYTES + 1), 1'b1);
        send_request(MODE_QUERY, 32'hFFFF_FFF0, 20'hFFFFF, 1'b1);
        send_request(MODE_QUERY, b + 4095 * CARD_BYTES, 20'd256, 1'b1);
        send_request(MODE_QUERY, b + 4095 * CARD_BYTES, 20'd0, 1'b0);
        send_request(MODE_QUERY, 32'hFFFF_FFFF, 20'd0, 1'b0);
        send_request(MODE_QUERY, 32'h0, 20'd0, 1'b0);
        send_request(MODE_SPARE, b, 20'hFFFFF, 1'b1);
        send_request(MODE_QUERY, b, 20'd0, 1'b0);
        send_request(MODE_CLEAR, b, 20'd0, 1'b0);
        send_request(MODE_QUERY, b + CARD_BYTES, SPAN_W'(4094 * CARD_BYTES + 1), 1'b1);
        send_request(MODE_QUERY, b, 20'hFFFFF, 1'b1);
        send_request(MODE_MARK,  32'hFFFF_FFFF, 20'd0, 1'b0);
        send_request(MODE_MARK,  b + 2 * CARD_BYTES + 64, 20'd0, 1'b0);
        send_request(MODE_QUERY, b + CARD_BYTES + 100, 20'd200, 1'b1);
        wait_drained();

        // Random phases, each under its own register setting
        for (ph = 0; ph < 7; ph++)
        begin
            repeat (8) @(posedge clk);
            case (ph)
                0:
                begin
                    set_table(32'h0, 13'd4096);
                    n_items = 90;
                end
                1:
                begin
                    set_table($urandom, 13'd8191);
                    n_items = 90;
                end
                2:
                begin
                    set_table(32'hFFFF_FFFF, 13'd1);
                    n_items = 40;
                end
                3:
                begin
                    set_table($urandom, 13'd0);
                    n_items = 40;
                end
                4:
                begin
                    set_table($urandom, 13'($urandom_range(2, 64)));
                    n_items = 110;
                end
                5:
                begin
                    set_table($urandom, 13'($urandom_range(4097, 8190)));
                    n_items = 90;
                end
                default:
                begin
                    set_table($urandom, 13'($urandom_range(65, 4096)));
                    n_items = 110;
                end
            endcase
            tx_gap_pct = $urandom_range(0, 25);

            // Clear the whole table while no card is in use
            if (ph == 3)
                send_request(MODE_CLEAR, cur_base, 20'd0, 1'b0);

            for (i = 0; i < n_items; i++)
            begin
                tail = (ph == 6) && (i >= n_items - 60);
                if (tail && !quiet)
                    quiet <= 1'b1;
                if (!tail && $urandom_range(0, 99) < tx_gap_pct)
                    idle_gap($urandom_range(1, 13));
                if (!tail && i == n_items / 2)
                    wait_drained();
                if ((ph == 1 || ph == 4) && i == n_items / 4)
                    rx_hold_req <= rx_hold_req + 1;
                send_random_request();
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("tb: %0d requests (%0d mark, %0d query, %0d clear, %0d spare) over %0d settings",
                 n_marks + n_queries + n_clears + n_spare, n_marks, n_queries, n_clears,
                 n_spare, n_settings);
        $display("tb: %0d replies compared, %0d dirty, %0d out of range, %0d still awaited",
                 replies_seen, dirty_seen, oor_seen, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gc_ct_pkg.sv
rtl/gc_ct_ram.sv
rtl/gc_ct_fifo.sv
rtl/gc_ct_front.sv
rtl/gc_ct_back.sv
rtl/gc_card_table_engine_core.sv
rtl/gc_ct_checker.sv
tb/gc_card_table_checker.sv
tb/tb.sv
